[sv/mhpa_pkg.sv]
// Shared types, constants and state codes of the motion hot-point accumulator.
package mhpa_pkg;

    // Fixed field widths of the transaction payloads and the config port
    localparam int ACC_W      = 24;
    localparam int GREY_W     = 8;
    localparam int HX_W       = 14;
    localparam int HY_W       = 13;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 10;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [CFG_W_W-1:0]    RST_FRAME_WIDTH     = 11'd640;
    localparam logic [CFG_H_W-1:0]    RST_FRAME_HEIGHT    = 10'd480;
    localparam logic [CFG_DATA_W-1:0] RST_POWER_THRESHOLD = 24'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_POWER_THRESHOLD = 2'd2
    } cfg_index_t;

    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [GREY_W-1:0] current_pixel;
        logic [GREY_W-1:0] previous_pixel;
    } mhpa_in_t;

    typedef struct packed {
        logic [ACC_W-1:0] peak_power;
        logic [HX_W-1:0]  hot_x;
        logic [HY_W-1:0]  hot_y;
        logic             threshold_crossed;
    } mhpa_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_REDUCE,
        ST_READ,
        ST_SUM,
        ST_UPDATE,
        ST_START_X,
        ST_DIV_X,
        ST_START_Y,
        ST_DIV_Y,
        ST_FINISH
    } mhpa_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic addr;
        logic reduce;
        logic read;
        logic sum;
        logic update;
        logic div_start_x;
        logic capture_x;
        logic div_start_y;
        logic finish;
    } mhpa_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic reduce_last;
        logic frame_end;
        logic div_busy;
        logic out_full;
    } mhpa_status_t;

endpackage

[sv/mhpa_div.sv]
// Restoring divider, one quotient bit per cycle.
module mhpa_div
    import mhpa_pkg::*;
#(
    parameter int DVD_W = 33,
    parameter int DVS_W = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int SC_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [SC_W-1:0]  step_reg;
    logic             busy_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] trial;
    logic           fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= SC_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - SC_W'(1);
            if (step_reg == SC_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DVS_W'(trial) : DVS_W'(shifted);
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

[sv/mhpa_ctrl.sv]
// Sequencing state machine of the motion hot-point accumulator.
module mhpa_ctrl
    import mhpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_kind,
    output logic         in_ready,
    input  mhpa_status_t status,
    output mhpa_cmd_t    cmd
);

    mhpa_state_t state_reg;
    mhpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_kind != KIND_CLEAR))
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:    state_next = ST_REDUCE;
            ST_REDUCE:
            begin
                if (status.reduce_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_UPDATE;
            ST_UPDATE:  state_next = status.frame_end ? ST_START_X : ST_IDLE;
            ST_START_X: state_next = ST_DIV_X;
            ST_DIV_X:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y: state_next = ST_DIV_Y;
            ST_DIV_Y:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid && (in_kind != KIND_CLEAR);
                cmd.clear = in_valid && (in_kind == KIND_CLEAR);
            end
            ST_ADDR:    cmd.addr = 1'b1;
            ST_REDUCE:  cmd.reduce = 1'b1;
            ST_READ:    cmd.read = 1'b1;
            ST_SUM:     cmd.sum = 1'b1;
            ST_UPDATE:  cmd.update = 1'b1;
            ST_START_X: cmd.div_start_x = 1'b1;
            ST_DIV_X:   cmd.capture_x = !status.div_busy;
            ST_START_Y: cmd.div_start_y = 1'b1;
            ST_DIV_Y:   cmd = '0;
            ST_FINISH:  cmd.finish = !status.out_full;
            default:    cmd = '0;
        endcase
    end

endmodule

[sv/mhpa_dpath.sv]
// Datapath: accumulator store, peak tracking, centroid divide and result register.
module mhpa_dpath
    import mhpa_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 512,
    parameter int STORE_DEPTH = 524288,
    parameter int FRAC_BITS   = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_W_W-1:0]    cfg_frame_width,
    input  logic [CFG_H_W-1:0]    cfg_frame_height,
    input  logic [CFG_DATA_W-1:0] cfg_power_threshold,
    input  mhpa_in_t              in_data,
    input  mhpa_cmd_t             cmd,
    output mhpa_status_t          status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mhpa_out_t             out_data
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WV_W      = $clog2(MAX_WIDTH + 1);
    localparam int HV_W      = $clog2(MAX_HEIGHT + 1);
    localparam int PIX_CNT   = MAX_WIDTH * MAX_HEIGHT;
    localparam int PROD_W    = $clog2(PIX_CNT);
    localparam int CNT_W     = PROD_W + 1;
    localparam int SX_W      = COL_W + PROD_W;
    localparam int SY_W      = ROW_W + PROD_W;
    localparam int DVD_W     = ((SX_W > SY_W) ? SX_W : SY_W) + FRAC_BITS;
    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int RED_STEPS = $clog2((PIX_CNT + STORE_DEPTH - 1) / STORE_DEPTH);
    localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    // effective frame size
    logic [WV_W-1:0] w_eff;
    logic [HV_W-1:0] h_eff;

    always_comb
    begin
        if (cfg_frame_width == '0)
            w_eff = WV_W'(1);
        else if (32'(cfg_frame_width) > MAX_WIDTH)
            w_eff = WV_W'(MAX_WIDTH);
        else
            w_eff = WV_W'(cfg_frame_width);

        if (cfg_frame_height == '0)
            h_eff = HV_W'(1);
        else if (32'(cfg_frame_height) > MAX_HEIGHT)
            h_eff = HV_W'(MAX_HEIGHT);
        else
            h_eff = HV_W'(cfg_frame_height);
    end

    // pass state
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [ACC_W-1:0] peak_reg;
    logic [SX_W-1:0]  sumx_reg;
    logic [SY_W-1:0]  sumy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pending_reg;

    // per-item payload
    logic [GREY_W-1:0] diff_reg;
    logic [PROD_W-1:0] addr_reg;
    logic [ACC_W-1:0]  rd_data_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic [HX_W-1:0]   qx_reg;
    mhpa_out_t         out_data_reg;
    logic              out_valid_reg;

    logic [ACC_W-1:0] store_mem [STORE_DEPTH];

    logic [WV_W-1:0]  col_inc;
    logic [HV_W-1:0]  row_inc;
    logic             end_row;
    logic             frame_end;
    logic             crossed;
    logic [AW-1:0]    mem_addr;
    logic [ACC_W-1:0] old_val;
    logic [ACC_W:0]   wide_sum;

    logic [PROD_W-1:0] red_cmp;
    logic              red_sub;
    logic              reduce_last;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    logic             div_busy;
    logic [DVD_W-1:0] div_quotient;

    assign col_inc   = WV_W'(col_reg) + WV_W'(1);
    assign row_inc   = HV_W'(row_reg) + HV_W'(1);
    assign end_row   = col_inc >= w_eff;
    assign frame_end = end_row && (row_inc >= h_eff);
    assign crossed   = peak_reg > cfg_power_threshold;
    assign mem_addr  = AW'(addr_reg);

    assign old_val  = pending_reg ? '0 : rd_data_reg;
    assign wide_sum = {1'b0, old_val} + (ACC_W + 1)'(diff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            peak_reg    <= '0;
            sumx_reg    <= '0;
            sumy_reg    <= '0;
            cnt_reg     <= '0;
            pending_reg <= 1'b1;
        end
        else if (cmd.clear || cmd.finish)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            peak_reg    <= '0;
            sumx_reg    <= '0;
            sumy_reg    <= '0;
            cnt_reg     <= '0;
            pending_reg <= cmd.clear ? 1'b1 : crossed;
        end
        else if (cmd.load)
        begin
            // size may have changed since the last pixel
            if (WV_W'(col_reg) >= w_eff)
                col_reg <= '0;
            if (HV_W'(row_reg) >= h_eff)
                row_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (sum_reg > peak_reg)
            begin
                peak_reg <= sum_reg;
                sumx_reg <= SX_W'(col_reg);
                sumy_reg <= SY_W'(row_reg);
                cnt_reg  <= CNT_W'(1);
            end
            else if (sum_reg == peak_reg)
            begin
                sumx_reg <= sumx_reg + SX_W'(col_reg);
                sumy_reg <= sumy_reg + SY_W'(row_reg);
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end

            if (end_row)
            begin
                col_reg <= '0;
                row_reg <= ROW_W'(row_inc);
            end
            else
            begin
                col_reg <= COL_W'(col_inc);
            end
        end
    end

    // address modulo the store depth, one restoring step per cycle
    generate
        if (RED_STEPS > 0)
        begin : g_red
            logic [RK_W-1:0] red_k_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    red_k_reg <= '0;
                else if (cmd.addr)
                    red_k_reg <= RK_W'(RED_STEPS - 1);
                else if (cmd.reduce && (red_k_reg != '0))
                    red_k_reg <= red_k_reg - RK_W'(1);
            end

            assign red_cmp     = PROD_W'(STORE_DEPTH) << red_k_reg;
            assign red_sub     = cmd.reduce && (addr_reg >= red_cmp);
            assign reduce_last = (red_k_reg == '0);
        end
        else
        begin : g_nored
            assign red_cmp     = '0;
            assign red_sub     = 1'b0;
            assign reduce_last = 1'b1;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            diff_reg <= (in_data.current_pixel > in_data.previous_pixel) ?
                        in_data.current_pixel - in_data.previous_pixel :
                        in_data.previous_pixel - in_data.current_pixel;

        if (cmd.addr)
            addr_reg <= PROD_W'(row_reg) * PROD_W'(w_eff) + PROD_W'(col_reg);
        else if (red_sub)
            addr_reg <= addr_reg - red_cmp;

        if (cmd.sum)
            sum_reg <= wide_sum[ACC_W] ? ACC_MAX : wide_sum[ACC_W-1:0];

        if (cmd.capture_x)
            qx_reg <= HX_W'(div_quotient);
    end

    // single-port store: read in one state, write back in another
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            rd_data_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
            store_mem[mem_addr] <= sum_reg;
    end

    assign div_start    = cmd.div_start_x || cmd.div_start_y;
    assign div_dividend = cmd.div_start_y ? (DVD_W'(sumy_reg) << FRAC_BITS) :
                                            (DVD_W'(sumx_reg) << FRAC_BITS);
    assign div_divisor  = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;

    mhpa_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.peak_power        <= peak_reg;
            out_data_reg.hot_x             <= qx_reg;
            out_data_reg.hot_y             <= HY_W'(div_quotient);
            out_data_reg.threshold_crossed <= crossed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.reduce_last = reduce_last;
    assign status.frame_end   = frame_end;
    assign status.div_busy    = div_busy;
    assign status.out_full    = out_valid_reg && !out_ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken transaction");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (cnt_reg != '0))
        else $error("frame finished with no peak pixel counted");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result valid without a frame finish");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (32'(addr_reg) < STORE_DEPTH))
        else $error("store address not reduced below depth");

endmodule

[sv/motion_hot_point_accumulator.sv]
// Top level of the motion hot-point accumulator: config registers, controller, datapath.
//
// Each pixel transaction carries a current/previous grey pair; the block adds
// their absolute difference into the accumulator entry at row*width+column
// (modulo STORE_DEPTH), saturating at 24 bits, and keeps the frame's peak plus
// the coordinate sums and count of pixels equal to it. The last pixel of a
// frame produces one result transaction: the peak, the centroid of the peak
// pixels with FRAC_BITS fraction bits (truncated), and threshold_crossed when
// the peak is above power_threshold, which also schedules a store clear. A
// clear transaction (kind = 1) restarts the frame and schedules the clear;
// the clear is lazy, the next frame reads zeros. A pixel transaction runs
// the read-modify-write sequence on the single-port store, preceded by
// RED_STEPS address reduction steps, the number needed when the maximum
// frame area exceeds STORE_DEPTH. The last pixel of a frame also runs the
// two centroid divides on the shared bit-serial divider, DVD_W bits wide,
// the wider coordinate sum width plus FRAC_BITS. A new frame is accepted
// while the previous result waits in the output register; the block only
// stalls at the next frame end if that result is still untaken. The store
// needs no initialization pass. Frame width and height of zero act as one and
// values above MAX_WIDTH / MAX_HEIGHT act as the maximum; config writes are
// taken at any cycle with cfg_write_en high and are meant for idle periods.
module motion_hot_point_accumulator
    import mhpa_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 512,
    parameter int STORE_DEPTH = 524288,
    parameter int FRAC_BITS   = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mhpa_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mhpa_out_t             out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_W_W-1:0]    frame_width_reg;
    logic [CFG_H_W-1:0]    frame_height_reg;
    logic [CFG_DATA_W-1:0] power_threshold_reg;

    mhpa_cmd_t    cmd;
    mhpa_status_t status;

    // Config registers; writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= RST_FRAME_WIDTH;
            frame_height_reg    <= RST_FRAME_HEIGHT;
            power_threshold_reg <= RST_POWER_THRESHOLD;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[CFG_W_W-1:0];
                CFG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[CFG_H_W-1:0];
                CFG_POWER_THRESHOLD: power_threshold_reg <= cfg_data;
                default:             frame_width_reg     <= frame_width_reg;
            endcase
        end
    end

    // Sequencer: one transaction at a time through the store access states,
    // then the two divides and the result load at frame end
    mhpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, peak tracking, divider and the output register
    mhpa_dpath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_frame_width     (frame_width_reg),
        .cfg_frame_height    (frame_height_reg),
        .cfg_power_threshold (power_threshold_reg),
        .in_data             (in_data),
        .cmd                 (cmd),
        .status              (status),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .out_data            (out_data)
    );

endmodule
